@@ rtl/hsl2rgb_pkg.sv @@
package hsl2rgb_pkg;

  // pipeline depth: four stages of colour maths, three of quantising
  localparam int unsigned NUM_STAGES  = 7;
  localparam int unsigned QUANT_FIRST = 4;

  // field widths
  localparam int unsigned HUE_W  = 10;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CHAN_W = 8;

  // fixed point: 600000 stands for full scale
  localparam int unsigned VAL_W      = 20;
  localparam int unsigned KS_W       = 14;
  localparam int unsigned SCALE_HALF = 300000;

  // quantiser: (v * 255 + half) / 600000, with 600000 = 64 * 9375
  localparam int unsigned QUANT_SHIFT = 6;
  localparam int unsigned QUANT_DIV   = 9375;
  localparam int unsigned PROD_W      = 28;
  localparam int unsigned QIN_W       = PROD_W - QUANT_SHIFT;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] QUANT_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd9375);

  // 60 degree sectors of the hue circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYA = 3'd2,
    SEC_CYA_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

@@ rtl/hsl2rgb_in_if.sv @@
interface hsl2rgb_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsl2rgb_pkg::HUE_W-1:0]  hue;
  logic [hsl2rgb_pkg::PCT_W-1:0]  saturation;
  logic [hsl2rgb_pkg::PCT_W-1:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

@@ rtl/hsl2rgb_out_if.sv @@
interface hsl2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsl2rgb_pkg::CHAN_W-1:0] red;
  logic [hsl2rgb_pkg::CHAN_W-1:0] green;
  logic [hsl2rgb_pkg::CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

@@ rtl/hsl2rgb_ctrl.sv @@
module hsl2rgb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output hsl2rgb_pkg::pipe_ctl_t ctl_o
);

  logic [hsl2rgb_pkg::NUM_STAGES-1:0] valid_q, valid_d, en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[hsl2rgb_pkg::NUM_STAGES-1] = !valid_q[hsl2rgb_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = hsl2rgb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < hsl2rgb_pkg::NUM_STAGES; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[hsl2rgb_pkg::NUM_STAGES-1];
  assign ctl_o.en    = en;

endmodule

@@ rtl/hsl2rgb_front.sv @@
module hsl2rgb_front (
  input  logic                                clk_i,
  input  hsl2rgb_pkg::pipe_ctl_t              ctl_i,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]       hue_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]       saturation_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]       lightness_i,
  output logic [hsl2rgb_pkg::VAL_W-1:0]       red_val_o,
  output logic [hsl2rgb_pkg::VAL_W-1:0]       green_val_o,
  output logic [hsl2rgb_pkg::VAL_W-1:0]       blue_val_o
);

  localparam int unsigned VW = hsl2rgb_pkg::VAL_W;
  localparam int unsigned KW = hsl2rgb_pkg::KS_W;
  localparam int unsigned PW = hsl2rgb_pkg::PCT_W;

  // stage 1: hue wrap, percent clamp
  logic [8:0]    h1_q, h1_d;
  logic [PW-1:0] s1_q, s1_d, l1_q, l1_d;

  always_comb begin
    if (hue_i >= 10'd720) begin
      h1_d = 9'(hue_i - 10'd720);
    end else if (hue_i >= 10'd360) begin
      h1_d = 9'(hue_i - 10'd360);
    end else begin
      h1_d = hue_i[8:0];
    end
    s1_d = (saturation_i > 7'd100) ? 7'd100 : saturation_i;
    l1_d = (lightness_i > 7'd100) ? 7'd100 : lightness_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      h1_q <= h1_d;
      s1_q <= s1_d;
      l1_q <= l1_d;
    end
  end

  // stage 2: k * s, sector and secondary weight
  logic [7:0]             l2x;
  logic [PW-1:0]          k2;
  logic [6:0]             hm2;
  logic [5:0]             dist2;
  logic [KW-1:0]          ks2_q, ks2_d;
  logic [5:0]             w2_q, w2_d;
  hsl2rgb_pkg::sector_e   sec2_q, sec2_d;
  logic [PW-1:0]          l2_q;

  always_comb begin
    l2x  = {l1_q, 1'b0};
    k2   = (l2x >= 8'd100) ? 7'(8'd200 - l2x) : l2x[PW-1:0];
    ks2_d = KW'(k2) * KW'(s1_q);
    if (h1_q >= 9'd300)      sec2_d = hsl2rgb_pkg::SEC_MAG_RED;
    else if (h1_q >= 9'd240) sec2_d = hsl2rgb_pkg::SEC_BLU_MAG;
    else if (h1_q >= 9'd180) sec2_d = hsl2rgb_pkg::SEC_CYA_BLU;
    else if (h1_q >= 9'd120) sec2_d = hsl2rgb_pkg::SEC_GRN_CYA;
    else if (h1_q >= 9'd60)  sec2_d = hsl2rgb_pkg::SEC_YEL_GRN;
    else                     sec2_d = hsl2rgb_pkg::SEC_RED_YEL;
    // hue within its 120 degree pair
    if (h1_q >= 9'd240)      hm2 = 7'(h1_q - 9'd240);
    else if (h1_q >= 9'd120) hm2 = 7'(h1_q - 9'd120);
    else                     hm2 = h1_q[6:0];
    dist2 = (hm2 >= 7'd60) ? 6'(hm2 - 7'd60) : 6'(7'd60 - hm2);
    w2_d  = 6'd60 - dist2;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      ks2_q  <= ks2_d;
      w2_q   <= w2_d;
      sec2_q <= sec2_d;
      l2_q   <= l1_q;
    end
  end

  // stage 3: chroma, secondary and lightness offset
  logic [VW-1:0]        c3_q, c3_d, x3_q, x3_d, m3_q, m3_d;
  hsl2rgb_pkg::sector_e sec3_q;

  always_comb begin
    c3_d = VW'(ks2_q) * VW'(60);
    x3_d = VW'(ks2_q) * VW'(w2_q);
    m3_d = VW'(l2_q) * VW'(6000) - VW'(ks2_q) * VW'(30);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      c3_q   <= c3_d;
      x3_q   <= x3_d;
      m3_q   <= m3_d;
      sec3_q <= sec2_q;
    end
  end

  // stage 4: channel order by sector, add offset
  logic [VW-1:0] r4_q, r4_d, g4_q, g4_d, b4_q, b4_d;
  logic [VW-1:0] r1, g1, b1;

  always_comb begin
    case (sec3_q)
      hsl2rgb_pkg::SEC_RED_YEL: begin r1 = c3_q; g1 = x3_q; b1 = '0;   end
      hsl2rgb_pkg::SEC_YEL_GRN: begin r1 = x3_q; g1 = c3_q; b1 = '0;   end
      hsl2rgb_pkg::SEC_GRN_CYA: begin r1 = '0;   g1 = c3_q; b1 = x3_q; end
      hsl2rgb_pkg::SEC_CYA_BLU: begin r1 = '0;   g1 = x3_q; b1 = c3_q; end
      hsl2rgb_pkg::SEC_BLU_MAG: begin r1 = x3_q; g1 = '0;   b1 = c3_q; end
      default:                  begin r1 = c3_q; g1 = '0;   b1 = x3_q; end
    endcase
    r4_d = r1 + m3_q;
    g4_d = g1 + m3_q;
    b4_d = b1 + m3_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      r4_q <= r4_d;
      g4_q <= g4_d;
      b4_q <= b4_d;
    end
  end

  assign red_val_o   = r4_q;
  assign green_val_o = g4_q;
  assign blue_val_o  = b4_q;

endmodule

@@ rtl/hsl2rgb_quant.sv @@
module hsl2rgb_quant (
  input  logic                          clk_i,
  input  hsl2rgb_pkg::pipe_ctl_t        ctl_i,
  input  logic [hsl2rgb_pkg::VAL_W-1:0] val_i,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] chan_o
);

  localparam int unsigned PW   = hsl2rgb_pkg::PROD_W;
  localparam int unsigned UW   = hsl2rgb_pkg::QIN_W;
  localparam int unsigned MW   = UW + hsl2rgb_pkg::RECIP_W;
  localparam int unsigned CW   = hsl2rgb_pkg::CHAN_W;
  localparam int unsigned ST_A = hsl2rgb_pkg::QUANT_FIRST;

  // stage a: scale by 255, add half, drop the power of two
  logic [PW-1:0] t_a;
  logic [UW-1:0] u_a_q;

  assign t_a = PW'(val_i) * PW'(255) + PW'(hsl2rgb_pkg::SCALE_HALF);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_A]) u_a_q <= t_a[PW-1:hsl2rgb_pkg::QUANT_SHIFT];
  end

  // stage b: reciprocal estimate, low by at most one
  logic [MW-1:0] prod_b;
  logic [CW-1:0] q0_b_q;
  logic [UW-1:0] u_b_q;

  assign prod_b = MW'(u_a_q) * MW'(hsl2rgb_pkg::QUANT_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_A+1]) begin
      q0_b_q <= prod_b[hsl2rgb_pkg::RECIP_SHIFT +: CW];
      u_b_q  <= u_a_q;
    end
  end

  // stage c: remainder check and correction
  logic [UW-1:0] rem_c;
  logic [CW-1:0] q_c_q, q_c_d;

  always_comb begin
    rem_c = u_b_q - UW'(q0_b_q) * UW'(hsl2rgb_pkg::QUANT_DIV);
    q_c_d = (rem_c >= UW'(hsl2rgb_pkg::QUANT_DIV)) ? q0_b_q + 8'd1 : q0_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_A+2]) q_c_q <= q_c_d;
  end

  assign chan_o = q_c_q;

endmodule

@@ rtl/hsl_to_rgb_converter.sv @@
// hsl to rgb colour converter
// in_i  : sink channel, one colour per word: hue in degrees (wrapped modulo
//         360), saturation and lightness in percent (clamped to 100)
// out_o : source channel, one 8-bit red, green, blue word per input word
// handshake: a word moves on a rising edge with valid and ready both high
// pipeline: four stages of colour maths, then three per channel to quantise;
//   out_o.valid is the valid bit of the last stage
// throughput: one word per cycle while out_o.ready is high; every stage has its own valid bit
// stall: when out_o.ready is low the last stage holds its word, earlier
//   stages still fill their empty slots, and in_i.ready drops only once
//   all seven stages are full; nothing is dropped or repeated
// reset: rst_ni is asynchronous and clears every valid bit, so the pipe
//   comes up empty and ready at once
module hsl_to_rgb_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_in_if.sink    in_i,
  hsl2rgb_out_if.source out_o
);

  hsl2rgb_pkg::pipe_ctl_t             ctl;
  logic [hsl2rgb_pkg::VAL_W-1:0]      red_val, green_val, blue_val;

  // stage valids and load enables
  hsl2rgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  // colour maths
  hsl2rgb_front u_front (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .hue_i        (in_i.hue),
    .saturation_i (in_i.saturation),
    .lightness_i  (in_i.lightness),
    .red_val_o    (red_val),
    .green_val_o  (green_val),
    .blue_val_o   (blue_val)
  );

  // one quantiser per channel
  hsl2rgb_quant u_quant_red (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .val_i  (red_val),
    .chan_o (out_o.red)
  );

  hsl2rgb_quant u_quant_green (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .val_i  (green_val),
    .chan_o (out_o.green)
  );

  hsl2rgb_quant u_quant_blue (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .val_i  (blue_val),
    .chan_o (out_o.blue)
  );

  // back-pressure only comes from a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without an output stall");

  // a full pipe stays full while the output stays stalled
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready ##1 !out_o.ready |-> !in_i.ready)
    else $error("full pipeline lost a word under stall");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hsl2rgb_pkg::*;

  // run shape
  localparam int NUM_RANDOM     = 1400;
  localparam int HOLD_AT        = 400;
  localparam int PAUSE_AT       = 900;
  localparam int LONG_HOLD      = 60;
  localparam int LONG_BURST     = 90;
  localparam int MAX_BURST      = 48;
  localparam int MAX_GAP        = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * NUM_STAGES;

  // fixed point full scale for one channel
  localparam longint unsigned FULL_SCALE = 600000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] light;
  } hsl_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_word_t;

  typedef struct packed {
    hsl_word_t src;
    rgb_word_t rgb;
  } rgb_expect_t;

  // one row of the directed table; typed rows carry their own colour
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [PCT_W-1:0]  sat;
    logic [PCT_W-1:0]  light;
    logic              typed;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_row_t;

  // receiver pacing modes
  typedef enum int {
    RX_STEADY = 0,
    RX_LIGHT  = 1,
    RX_TOGGLE = 2,
    RX_HEAVY  = 3
  } sink_mode_e;

  localparam int NUM_DIRECTED = 25;

  colour_row_t colour_table [NUM_DIRECTED] = '{
    // black, white, clamped white and clamped black
    '{10'd0,    7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{10'd0,    7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd255},
    '{10'd1023, 7'd127, 7'd127, 1'b1, 8'd255, 8'd255, 8'd255},
    '{10'd1023, 7'd0,   7'd127, 1'b1, 8'd255, 8'd255, 8'd255},
    '{10'd120,  7'd100, 7'd127, 1'b1, 8'd255, 8'd255, 8'd255},
    '{10'd700,  7'd127, 7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    // primaries and secondaries at every sector edge
    '{10'd0,    7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
    '{10'd60,   7'd100, 7'd50,  1'b1, 8'd255, 8'd255, 8'd0},
    '{10'd120,  7'd100, 7'd50,  1'b1, 8'd0,   8'd255, 8'd0},
    '{10'd180,  7'd100, 7'd50,  1'b1, 8'd0,   8'd255, 8'd255},
    '{10'd240,  7'd100, 7'd50,  1'b1, 8'd0,   8'd0,   8'd255},
    '{10'd300,  7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd255},
    // hue wrap and saturation clamp
    '{10'd360,  7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
    '{10'd720,  7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
    '{10'd0,    7'd127, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
    // grey, and grey landing on an exact half
    '{10'd0,    7'd0,   7'd50,  1'b1, 8'd128, 8'd128, 8'd128},
    '{10'd0,    7'd0,   7'd10,  1'b1, 8'd26,  8'd26,  8'd26},
    // mid sector hues and odd corners, checked against the predictor
    '{10'd30,   7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd90,   7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd150,  7'd80,  7'd40,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd210,  7'd60,  7'd70,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd270,  7'd100, 7'd25,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd330,  7'd45,  7'd90,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd359,  7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{10'd1023, 7'd101, 7'd99,  1'b0, 8'd0,   8'd0,   8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  hsl2rgb_in_if  in_if ();
  hsl2rgb_out_if out_if ();

  hsl_to_rgb_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // expected colours, oldest first
  rgb_expect_t rgb_expect_q [$];

  // expectation that travels with the offered word
  logic      offered_typed;
  rgb_word_t offered_rgb;

  int  error_count     = 0;
  int  words_checked   = 0;
  int  in_stall_cycles = 0;
  int  long_holds      = 0;
  int  idle_cycles     = 0;
  int  burst_left      = 1;
  bit  hold_off_req    = 1'b0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round half up from value * 255 at full scale
  function automatic logic [CHAN_W-1:0] quantise_channel(input longint unsigned v);
    longint unsigned q;
    q = (v * 255 + SCALE_HALF) / FULL_SCALE;
    if (q > 255) q = 255;
    return CHAN_W'(q);
  endfunction

  // exact integer hsl to rgb
  function automatic rgb_word_t hsl_to_rgb_predict(input hsl_word_t w);
    int unsigned     hue_deg, sat_pct, light_pct, knee, ks, hue_mod, hue_dist;
    longint unsigned chroma, second, offset, r1, g1, b1;
    sector_e         sec;
    rgb_word_t       res;
    hue_deg   = int'(w.hue) % 360;
    sat_pct   = int'(w.sat);
    light_pct = int'(w.light);
    if (sat_pct > 100) sat_pct = 100;
    if (light_pct > 100) light_pct = 100;
    knee     = (2 * light_pct >= 100) ? 200 - 2 * light_pct : 2 * light_pct;
    ks       = knee * sat_pct;
    hue_mod  = hue_deg % 120;
    hue_dist = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
    chroma   = longint'(ks) * 60;
    second   = longint'(ks) * (60 - hue_dist);
    offset   = longint'(light_pct) * 6000 - longint'(ks) * 30;
    sec      = sector_e'(hue_deg / 60);
    case (sec)
      SEC_RED_YEL: begin r1 = chroma; g1 = second; b1 = 0;      end
      SEC_YEL_GRN: begin r1 = second; g1 = chroma; b1 = 0;      end
      SEC_GRN_CYA: begin r1 = 0;      g1 = chroma; b1 = second; end
      SEC_CYA_BLU: begin r1 = 0;      g1 = second; b1 = chroma; end
      SEC_BLU_MAG: begin r1 = second; g1 = 0;      b1 = chroma; end
      default:     begin r1 = chroma; g1 = 0;      b1 = second; end
    endcase
    res.red   = quantise_channel(r1 + offset);
    res.green = quantise_channel(g1 + offset);
    res.blue  = quantise_channel(b1 + offset);
    return res;
  endfunction

  // offer one word and wait for it to be taken
  task automatic offer_word(input hsl_word_t w, input logic typed, input rgb_word_t rgb);
    in_if.valid      <= 1'b1;
    in_if.hue        <= w.hue;
    in_if.saturation <= w.sat;
    in_if.lightness  <= w.light;
    offered_typed    <= typed;
    offered_rgb      <= rgb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // after a word: carry on the burst, take a gap, or drain the block
  task automatic finish_word(input bit drain);
    if (drain) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while (rgb_expect_q.size() != 0);
    end else begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
        burst_left = $urandom_range(1, MAX_BURST);
      end
    end
  endtask

  // sender: reset, directed table, then random colours
  initial begin : sender
    hsl_word_t w;
    in_if.valid      <= 1'b0;
    in_if.hue        <= '0;
    in_if.saturation <= '0;
    in_if.lightness  <= '0;
    offered_typed    <= 1'b0;
    offered_rgb      <= '0;
    rst_ni           <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, drained at the end
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      w.hue   = colour_table[i].hue;
      w.sat   = colour_table[i].sat;
      w.light = colour_table[i].light;
      offer_word(w, colour_table[i].typed,
                 '{colour_table[i].red, colour_table[i].green, colour_table[i].blue});
      finish_word(i == NUM_DIRECTED - 1);
    end

    // random colours, mostly in range with some wrapped or clamped fields
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == HOLD_AT) begin
        hold_off_req = 1'b1;
        burst_left   = LONG_BURST;
      end
      w.hue   = ($urandom_range(0, 9) < 7) ? HUE_W'($urandom_range(0, 359))
                                           : HUE_W'($urandom_range(0, 1023));
      w.sat   = ($urandom_range(0, 4) != 0) ? PCT_W'($urandom_range(0, 100))
                                            : PCT_W'($urandom_range(0, 127));
      w.light = ($urandom_range(0, 4) != 0) ? PCT_W'($urandom_range(0, 100))
                                            : PCT_W'($urandom_range(0, 127));
      offer_word(w, 1'b0, '0);
      finish_word(i == PAUSE_AT || i == NUM_RANDOM - 1);
    end

    // let any stray word show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rgb_expect_q.size() != 0) error_count += rgb_expect_q.size();

    $display("covered %0d colour words (%0d from the table): all hue sectors, wrap and clamp",
             words_checked, NUM_DIRECTED);
    $display("input held off on %0d cycles, %0d long output stall(s), %0d error(s)",
             in_stall_cycles, long_holds, error_count);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin : receiver
    sink_mode_e mode;
    int         span;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_if.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          long_holds++;
        end
        case (mode)
          RX_STEADY: out_if.ready <= 1'b1;
          RX_LIGHT:  out_if.ready <= ($urandom_range(0, 9) < 7);
          RX_TOGGLE: out_if.ready <= ~out_if.ready;
          default:   out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // check each output word against the oldest expectation, then log new input
  always @(posedge clk_i) begin : colour_check
    rgb_expect_t exp_w;
    rgb_word_t   got_rgb;
    if (rst_ni === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got_rgb = '{out_if.red, out_if.green, out_if.blue};
        if (rgb_expect_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected word: rgb %0d,%0d,%0d", got_rgb.red, got_rgb.green,
                     got_rgb.blue);
        end else begin
          exp_w = rgb_expect_q.pop_front();
          words_checked++;
          if (got_rgb.red !== exp_w.rgb.red || got_rgb.green !== exp_w.rgb.green ||
              got_rgb.blue !== exp_w.rgb.blue) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: hsl %0d/%0d/%0d expected rgb %0d,%0d,%0d got %0d,%0d,%0d",
                       exp_w.src.hue, exp_w.src.sat, exp_w.src.light,
                       exp_w.rgb.red, exp_w.rgb.green, exp_w.rgb.blue,
                       got_rgb.red, got_rgb.green, got_rgb.blue);
          end
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        exp_w.src = '{in_if.hue, in_if.saturation, in_if.lightness};
        exp_w.rgb = offered_typed ? offered_rgb : hsl_to_rgb_predict(exp_w.src);
        rgb_expect_q.push_back(exp_w);
      end
      if (in_if.valid === 1'b1 && in_if.ready !== 1'b1) in_stall_cycles++;
    end
  end

  // watchdog on cycles with no word moved on either side
  always @(posedge clk_i) begin : watchdog
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no word moved, %0d still expected",
               idle_cycles, rgb_expect_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
